// ===== sv/rsbk_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package rsbk_pkg;

  localparam int MaxRecordsDef = 64;
  localparam int KeyW          = 32;
  localparam int TagW          = 6;
  localparam int CfgIdxW       = 1;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgSortKey    = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgDescending = 1'd1;

  typedef struct packed {
    logic signed [KeyW-1:0] id;
    logic signed [KeyW-1:0] phone;
    logic [TagW-1:0]        tag;
  } rsbk_rec_t;

  // per-cell command for one cycle
  typedef struct packed {
    logic load;     // take the incoming record
    logic shift;    // take the right neighbor's record
    logic sort_lo;  // lower cell of an active compare pair
    logic sort_hi;  // upper cell of an active compare pair
  } rsbk_ctl_t;

  typedef struct packed {
    logic sort_key;    // 0 identity, 1 phone
    logic descending;
  } rsbk_cfg_t;

  // true when record a must come strictly before record b
  function automatic logic goes_before(input rsbk_rec_t a, input rsbk_rec_t b,
                                       input rsbk_cfg_t cfg);
    logic signed [KeyW-1:0] ka;
    logic signed [KeyW-1:0] kb;
    ka = cfg.sort_key ? a.phone : a.id;
    kb = cfg.sort_key ? b.phone : b.id;
    return cfg.descending ? (ka > kb) : (ka < kb);
  endfunction

endpackage
`default_nettype wire

// ===== sv/record_sort_by_key.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel   | Direction | Handshake                  | Payload
// --------- | --------- | -------------------------- | ------------------------------------
// command   | in        | start_i & !busy_o          | id_number_i, phone_number_i,
//           |           |                            | record_tag_i, last_record_i
// result    | out       | out_valid_o (strobe)       | id_out_o, phone_out_o, tag_out_o,
//           |           |                            | last_out_o
// config    | in        | cfg_valid_i & cfg_ready_o  | cfg_index_i, cfg_data_i
//
// While busy_o is low, records load one per cycle into a row of cells, one
// record per cell. A set of n stored records (at most MAX_RECORDS), closed by
// the record marked last, then runs one odd-even compare/exchange pass per
// record and shifts the row out toward cell 0; busy_o is high from the
// closing transfer to the last shift. Each result is strobed in the cycle
// after the shift that takes it out, so the last one is on the ports as
// busy_o falls. The receiver cannot stall; cfg_ready_o is always high.
// Reset clears control and config only; the cells hold no reset value.
module record_sort_by_key #(
  parameter int MAX_RECORDS = rsbk_pkg::MaxRecordsDef
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  output logic                                     busy_o,
  input  wire logic signed [rsbk_pkg::KeyW-1:0]    id_number_i,
  input  wire logic signed [rsbk_pkg::KeyW-1:0]    phone_number_i,
  input  wire logic [rsbk_pkg::TagW-1:0]           record_tag_i,
  input  wire logic                                last_record_i,
  output logic                                     out_valid_o,
  output logic signed [rsbk_pkg::KeyW-1:0]         id_out_o,
  output logic signed [rsbk_pkg::KeyW-1:0]         phone_out_o,
  output logic [rsbk_pkg::TagW-1:0]                tag_out_o,
  output logic                                     last_out_o,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [rsbk_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  wire logic                                cfg_data_i
);
  import rsbk_pkg::*;

  localparam int CntW = $clog2(MAX_RECORDS + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_RECORDS);
  localparam logic [CntW-1:0] One    = CntW'(1);

  // controller states
  localparam logic [1:0] StLoad = 2'd0;
  localparam logic [1:0] StSort = 2'd1;
  localparam logic [1:0] StEmit = 2'd2;

  logic [1:0]      state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] pass_q, pass_d;
  rsbk_cfg_t       cfg_q;

  rsbk_rec_t       out_rec_q;
  logic            out_last_q;
  logic            out_valid_q;

  logic            accept;
  logic            in_sort;
  logic            in_emit;
  rsbk_rec_t       load_rec;

  rsbk_rec_t       cell_rec  [MAX_RECORDS];
  logic            cell_swap [MAX_RECORDS];
  rsbk_ctl_t       cell_ctl  [MAX_RECORDS];

  assign busy_o      = (state_q != StLoad);
  assign accept      = start_i && !busy_o;
  assign in_sort     = (state_q == StSort);
  assign in_emit     = (state_q == StEmit);
  assign cfg_ready_o = 1'b1;

  assign load_rec.id    = id_number_i;
  assign load_rec.phone = phone_number_i;
  assign load_rec.tag   = record_tag_i;

  // configuration writes; an index beyond the list is dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgSortKey:    cfg_q.sort_key   <= cfg_data_i;
        CfgDescending: cfg_q.descending <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer: load until the closing record, run one pass per record,
  // then drain the row through cell 0.
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    pass_d  = pass_q;
    unique case (state_q)
      StLoad: begin
        if (accept) begin
          // a record beyond capacity is dropped; its last mark still counts
          if (count_q != MaxCnt) begin
            count_d = count_q + One;
          end
          if (last_record_i) begin
            state_d = StSort;
            pass_d  = '0;
          end
        end
      end
      StSort: begin
        pass_d = pass_q + One;
        if (pass_q == count_q - One) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        count_d = count_q - One;
        if (count_q == One) begin
          state_d = StLoad;
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StLoad;
      count_q     <= '0;
      pass_q      <= '0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pass_q      <= pass_d;
      out_valid_q <= in_emit;
      out_last_q  <= in_emit && (count_q == One);
    end
  end

  // result payload: capture the head of the row as it shifts out
  always_ff @(posedge clk_i) begin
    if (in_emit) begin
      out_rec_q <= cell_rec[0];
    end
  end

  assign id_out_o    = out_rec_q.id;
  assign phone_out_o = out_rec_q.phone;
  assign tag_out_o   = out_rec_q.tag;
  assign last_out_o  = out_last_q;
  assign out_valid_o = out_valid_q;

  // the row of cells
  for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
    localparam logic IsOdd = (i % 2) == 1;
    rsbk_rec_t left_rec;
    rsbk_rec_t right_rec;
    logic      swap_in;

    // the pair (i, i+1) is active when its lower index matches the pass
    // parity and both cells hold records of this set
    assign cell_ctl[i].load    = accept && (count_q == CntW'(i));
    assign cell_ctl[i].shift   = in_emit;
    assign cell_ctl[i].sort_lo = in_sort && (pass_q[0] == IsOdd)
                                 && (CntW'(i + 1) < count_q);
    if (i == 0) begin : g_first
      assign left_rec         = cell_rec[i];
      assign swap_in          = 1'b0;
      assign cell_ctl[i].sort_hi = 1'b0;
    end else begin : g_inner
      assign left_rec         = cell_rec[i-1];
      assign swap_in          = cell_swap[i-1];
      assign cell_ctl[i].sort_hi = in_sort && (pass_q[0] != IsOdd)
                                   && (CntW'(i) < count_q);
    end
    if (i == MAX_RECORDS - 1) begin : g_last
      assign right_rec = cell_rec[i];
    end else begin : g_mid
      assign right_rec = cell_rec[i+1];
    end

    rsbk_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (cell_ctl[i]),
      .cfg_i   (cfg_q),
      .load_i  (load_rec),
      .left_i  (left_rec),
      .right_i (right_rec),
      .swap_i  (swap_in),
      .swap_o  (cell_swap[i]),
      .rec_o   (cell_rec[i])
    );
  end

`ifndef SYNTH
  // the store never holds more than its capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MaxCnt) else $error("record count above capacity");

  // the pass counter stays inside the set while sorting
  a_pass_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_sort |-> (pass_q < count_q)) else $error("sort pass beyond set size");

  // a result strobe always follows an output cycle
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ($past(state_q) == StEmit)) else $error("stray result strobe");

  // the final result leaves an empty store behind
  a_last_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_last_q |-> (count_q == '0 && state_q == StLoad))
    else $error("store not empty after final result");
`endif

endmodule
`default_nettype wire

// ===== sv/rsbk_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rsbk_cell (
  input  wire logic               clk_i,
  input  wire rsbk_pkg::rsbk_ctl_t ctl_i,
  input  wire rsbk_pkg::rsbk_cfg_t cfg_i,
  input  wire rsbk_pkg::rsbk_rec_t load_i,
  input  wire rsbk_pkg::rsbk_rec_t left_i,
  input  wire rsbk_pkg::rsbk_rec_t right_i,
  input  wire logic               swap_i,
  output logic                    swap_o,
  output rsbk_pkg::rsbk_rec_t     rec_o
);
  import rsbk_pkg::*;

  rsbk_rec_t rec_q, rec_d;

  // exchange only on a strict order violation, which keeps equal keys stable
  assign swap_o = ctl_i.sort_lo && goes_before(right_i, rec_q, cfg_i);

  always_comb begin
    rec_d = rec_q;
    priority if (ctl_i.load) begin
      rec_d = load_i;
    end else if (ctl_i.shift) begin
      rec_d = right_i;
    end else if (swap_o) begin
      rec_d = right_i;
    end else if (ctl_i.sort_hi && swap_i) begin
      rec_d = left_i;
    end else begin
      rec_d = rec_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign rec_o = rec_q;

endmodule
`default_nettype wire
